@@ design/ssi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stimulation safety interlock package
// Shared types, widths and codes for the safety interlock block.
// ----------------------------------------------------------------------------
package ssi_pkg;

    // Millisecond ticks that make up one second of session time.
    localparam int unsigned TICKS_PER_SECOND = 1000;
    localparam int unsigned PRESCALE_W       = 10;
    localparam int unsigned SECONDS_W        = 16;
    localparam int unsigned CFG_IDX_W        = 2;
    localparam int unsigned CFG_DATA_W       = 16;

    // Event kinds carried by an input transaction.
    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_CHECK     = 3'd1;
    localparam logic [2:0] KIND_START     = 3'd2;
    localparam logic [2:0] KIND_STOP      = 3'd3;
    localparam logic [2:0] KIND_RESET_ERR = 3'd4;
    localparam logic [2:0] KIND_ESTOP     = 3'd5;

    // Fault codes reported in error_code.
    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_IMP     = 2'd1;
    localparam logic [1:0] FAULT_CURRENT = 2'd2;
    localparam logic [1:0] FAULT_TIMEOUT = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_IMP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SESSION = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] MAX_IMP_RESET     = 16'd20;
    localparam logic [14:0] MAX_CURRENT_RESET = 15'd2000;
    localparam logic [15:0] MAX_SESSION_RESET = 16'd1800;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] current_ua;
        logic [15:0]        elec_imp;
    } t_in_item;

    typedef struct packed {
        logic                 all_ok;
        logic [1:0]           error_code;
        logic                 stim_on;
        logic                 stop_latched;
        logic                 zero_drive;
        logic [SECONDS_W-1:0] session_seconds;
        logic                 impedance_good;
        logic                 current_good;
        logic                 time_good;
    } t_out_item;

    typedef struct packed {
        logic [15:0] imp_limit;
        logic [14:0] max_current_ua;
        logic [15:0] max_session_sec;
    } t_cfg;

endpackage

@@ design/ssi_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Safety interlock configuration registers
// Holds the impedance, current and session time limits.
// ----------------------------------------------------------------------------
module ssi_cfg_regs
    import ssi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.imp_limit       <= MAX_IMP_RESET;
            r_cfg.max_current_ua  <= MAX_CURRENT_RESET;
            r_cfg.max_session_sec <= MAX_SESSION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAX_IMP:     r_cfg.imp_limit       <= i_cfg_data;
                REG_MAX_CURRENT: r_cfg.max_current_ua  <= i_cfg_data[14:0];
                REG_MAX_SESSION: r_cfg.max_session_sec <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/ssi_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Safety interlock core
// Session state, limit checks and emergency stop latch, one event per cycle when i_fire is high.
// ----------------------------------------------------------------------------
module ssi_core
    import ssi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic                  r_running, n_running;
    logic                  r_stim, n_stim;
    logic                  r_safe_stop, n_safe_stop;
    logic                  r_imp_flag, n_imp_flag;
    logic                  r_cur_flag, n_cur_flag;
    logic                  r_time_flag, n_time_flag;
    logic [1:0]            r_fault, n_fault;
    logic [PRESCALE_W-1:0] r_prescale, n_prescale;
    logic [SECONDS_W-1:0]  r_seconds, n_seconds;

    logic [PRESCALE_W-1:0] prescale_inc;
    logic [16:0]           cur_mag;
    logic                  imp_bad;
    logic                  cur_bad;
    logic                  time_bad;
    logic                  zero;

    // Magnitude of the signed current, 0 to 32768, and the three limit tests.
    always_comb begin
        if (i_item.current_ua[15]) begin
            cur_mag = 17'h10000 - {1'b0, i_item.current_ua};
        end else begin
            cur_mag = {1'b0, i_item.current_ua};
        end
        imp_bad      = i_item.elec_imp > i_cfg.imp_limit;
        cur_bad      = cur_mag > {2'b00, i_cfg.max_current_ua};
        time_bad     = r_running && (r_seconds >= i_cfg.max_session_sec);
        prescale_inc = r_prescale + PRESCALE_W'(1);
    end

    // Next state for the event being applied.
    always_comb begin
        n_running   = r_running;
        n_stim      = r_stim;
        n_safe_stop = r_safe_stop;
        n_imp_flag  = r_imp_flag;
        n_cur_flag  = r_cur_flag;
        n_time_flag = r_time_flag;
        n_fault     = r_fault;
        n_prescale  = r_prescale;
        n_seconds   = r_seconds;
        zero        = 1'b0;
        case (i_item.kind)
            KIND_TICK: begin
                if (r_running) begin
                    if (prescale_inc >= PRESCALE_W'(TICKS_PER_SECOND)) begin
                        n_prescale = '0;
                        if (r_seconds != '1) begin
                            n_seconds = r_seconds + SECONDS_W'(1);
                        end
                    end else begin
                        n_prescale = prescale_inc;
                    end
                end
            end
            KIND_CHECK: begin
                n_imp_flag  = !imp_bad;
                n_cur_flag  = !cur_bad;
                n_time_flag = !time_bad;
                // The fault code names one failing test: timeout first, then current, then impedance.
                if (time_bad) begin
                    n_fault = FAULT_TIMEOUT;
                end else if (cur_bad) begin
                    n_fault = FAULT_CURRENT;
                end else if (imp_bad) begin
                    n_fault = FAULT_IMP;
                end
                // Any failure, or a latched safe stop, forces an emergency stop.
                if (imp_bad || cur_bad || time_bad || r_safe_stop) begin
                    n_safe_stop = 1'b1;
                    n_stim      = 1'b0;
                    n_running   = 1'b0;
                    zero        = 1'b1;
                end
            end
            KIND_START: begin
                if (!r_running) begin
                    n_running   = 1'b1;
                    n_stim      = 1'b1;
                    n_safe_stop = 1'b0;
                    n_fault     = FAULT_NONE;
                    n_seconds   = '0;
                    n_prescale  = '0;
                end
            end
            KIND_STOP: begin
                n_running  = 1'b0;
                n_stim     = 1'b0;
                n_seconds  = '0;
                n_prescale = '0;
            end
            KIND_RESET_ERR: begin
                n_fault     = FAULT_NONE;
                n_safe_stop = 1'b0;
                n_imp_flag  = 1'b1;
                n_cur_flag  = 1'b1;
                n_time_flag = 1'b1;
            end
            KIND_ESTOP: begin
                n_safe_stop = 1'b1;
                n_stim      = 1'b0;
                n_running   = 1'b0;
                zero        = 1'b1;
            end
            default: ;
        endcase
    end

    // Status as it stands after the event.
    always_comb begin
        o_result.all_ok          = !n_safe_stop && n_imp_flag && n_cur_flag && n_time_flag;
        o_result.error_code      = n_fault;
        o_result.stim_on         = n_stim;
        o_result.stop_latched    = n_safe_stop;
        o_result.zero_drive      = zero;
        o_result.session_seconds = n_seconds;
        o_result.impedance_good  = n_imp_flag;
        o_result.current_good    = n_cur_flag;
        o_result.time_good       = n_time_flag;
    end

    // State update once per event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_stim      <= 1'b0;
            r_safe_stop <= 1'b0;
            r_imp_flag  <= 1'b1;
            r_cur_flag  <= 1'b1;
            r_time_flag <= 1'b1;
            r_fault     <= FAULT_NONE;
            r_prescale  <= '0;
            r_seconds   <= '0;
        end else if (i_fire) begin
            r_running   <= n_running;
            r_stim      <= n_stim;
            r_safe_stop <= n_safe_stop;
            r_imp_flag  <= n_imp_flag;
            r_cur_flag  <= n_cur_flag;
            r_time_flag <= n_time_flag;
            r_fault     <= n_fault;
            r_prescale  <= n_prescale;
            r_seconds   <= n_seconds;
        end
    end

endmodule

@@ design/stimulation_safety_interlock_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stimulation safety interlock unit
// Input register, interlock core and result register with valid/ready ports.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction is held in the input register, passes the core
// and is written to the result register once that register is free or emptying.
// Throughput: one transaction per cycle while the output side accepts, set by the
// single core pass between the input and result registers.
// Reset: synchronous and active low; limits return to 20 kohm, 2000 uA and
// 1800 s, the session is idle, no fault and all checks pass.
module stimulation_safety_interlock_unit
    import ssi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_cfg      cfg;
    t_out_item core_result;
    logic      core_fire;

    ssi_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The held transaction moves on when the result register is free or emptying.
    assign core_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || core_fire;

    ssi_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (core_fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_fire) begin
            r_out_item <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule
